// ----- design/segment_download_receiver_top_defines.svh -----
// Assertion macros used by the segment download receiver core RTL.
`ifndef SEGMENT_DOWNLOAD_RECEIVER_TOP_DEFINES_SVH
`define SEGMENT_DOWNLOAD_RECEIVER_TOP_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define SDR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define SDR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/sdr_pkg.sv -----
// Shared types and constants for the segment download receiver.
package sdr_pkg;

  // Pointer width; the pointer wraps at 2**AddrWidth
  localparam int AddrWidth = 32;

  localparam logic [7:0]  CmdSegment = 8'h73;  // 's'
  localparam logic [7:0]  CmdFinish  = 8'h66;  // 'f'
  localparam logic [31:0] BaseReset  = 32'h4000_0000;

  typedef enum logic [1:0] {
    ReplyNone = 2'd0,
    ReplyAck  = 2'd1,
    ReplyErr  = 2'd2
  } reply_kind_t;

  typedef struct packed {
    logic        write_valid;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    reply_kind_t reply_kind;
    logic        session_done;
  } result_t;

endpackage

// ----- design/sdr_in_reg.sv -----
// Input register holding one received byte until the core consumes it.
module sdr_in_reg
  import sdr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  // Take a new byte when empty or when the held one moves on this cycle
  assign in_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  // Capture payload on each transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// ----- design/sdr_core.sv -----
// Command decoder: phase, byte count, write pointer and base address.
`include "segment_download_receiver_top_defines.svh"

module sdr_core
  import sdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic [7:0]  byte_in,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        has_result,
  output result_t     result
);

  typedef enum logic [1:0] {
    PhCmd  = 2'd0,
    PhLen  = 2'd1,
    PhData = 2'd2
  } phase_t;

  phase_t                 phase;
  phase_t                 phase_next;
  logic [7:0]             count;
  logic [7:0]             count_next;
  logic [AddrWidth-1:0]   ptr;
  logic [AddrWidth-1:0]   ptr_next;
  logic [31:0]            base;

  // Decode the current byte against the phase
  always_comb begin
    phase_next = phase;
    count_next = count;
    ptr_next   = ptr;
    has_result = 1'b0;
    result     = '0;
    case (phase)
      PhLen: begin
        count_next = byte_in;
        if (byte_in == 8'd0) begin
          phase_next        = PhCmd;
          has_result        = 1'b1;
          result.reply_kind = ReplyAck;
        end else begin
          phase_next = PhData;
        end
      end
      PhData: begin
        has_result           = 1'b1;
        result.write_valid   = 1'b1;
        result.write_address = 32'(ptr);
        result.write_data    = byte_in;
        ptr_next             = ptr + 1'b1;
        count_next           = count - 8'd1;
        if (count == 8'd1) begin
          phase_next        = PhCmd;
          result.reply_kind = ReplyAck;
        end
      end
      default: begin
        phase_next = PhCmd;
        if (byte_in == CmdSegment) begin
          phase_next = PhLen;
        end else if (byte_in == CmdFinish) begin
          ptr_next            = AddrWidth'(base);
          has_result          = 1'b1;
          result.reply_kind   = ReplyAck;
          result.session_done = 1'b1;
        end else begin
          has_result        = 1'b1;
          result.reply_kind = ReplyErr;
        end
      end
    endcase
  end

  // Hold state; a base write also reloads the pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PhCmd;
      count <= 8'd0;
      ptr   <= AddrWidth'(BaseReset);
      base  <= BaseReset;
    end else begin
      if (step) begin
        phase <= phase_next;
        count <= count_next;
        ptr   <= ptr_next;
      end
      if (cfg_we) begin
        base <= cfg_wdata;
        ptr  <= AddrWidth'(cfg_wdata);
      end
    end
  end

  `SDR_ASSERT(a_data_count_nonzero, (phase == PhData) |-> (count != 8'd0), "data phase with zero count")
  `SDR_ASSERT(a_ptr_advance, (step && phase == PhData && !cfg_we) |=> (ptr == $past(ptr) + 1'b1), "pointer did not advance after write")
  `SDR_ASSERT(a_zero_len_returns, (step && phase == PhLen && byte_in == 8'd0) |=> (phase == PhCmd), "zero length did not return to command phase")
  `SDR_ASSERT_ALWAYS(a_reset_ptr_base, $past(rst) |-> (ptr == AddrWidth'(base)), "pointer not at base after reset")

endmodule

// ----- design/sdr_out_reg.sv -----
// Result register holding one result transaction until it is taken.
module sdr_out_reg
  import sdr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    load,
  input  result_t load_result,
  output logic    busy,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t held_result
);

  // Full and not being drained this cycle
  assign busy = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Capture payload when a new result arrives
  always_ff @(posedge clk) begin
    if (load) begin
      held_result <= load_result;
    end
  end

endmodule

// ----- design/segment_download_receiver_top.sv -----
// Segment download receiver: decodes received bytes into memory writes and replies.
//
// Input channel: in_valid/in_ready with rx_byte, one received byte per transaction.
// Output channel: out_valid/out_ready with write_valid, write_address, write_data,
// reply_kind and session_done. A byte gives zero or one result transaction: the
// 's' command and a non-zero length byte give none.
// Config: cfg_we writes cfg_wdata into the base address and reloads the write
// pointer in the same cycle; write only while the block is idle.
// Result path: an accepted byte sits in the input register and is decoded there,
// then the result register holds its result until it is taken.
// Throughput: one byte per cycle while the output is not stalled, set by the single
// decode step between the input register and the result register.
// Stall: while a result waits, the input register still accepts one byte;
// a byte that gives no result is consumed even while the output is stalled.
// Reset (rst, synchronous): command phase, count zero, base and pointer
// 0x40000000, both registers empty.
module segment_download_receiver_top
  import sdr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        write_valid,
  output logic [31:0] write_address,
  output logic [7:0]  write_data,
  output logic [1:0]  reply_kind,
  output logic        session_done
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       advance;
  logic       has_result;
  logic       out_busy;
  result_t    core_result;
  result_t    out_result;

  // Advance the held byte unless its result would hit a full output
  assign advance = held_valid && (!has_result || !out_busy);

  sdr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  sdr_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .byte_in    (held_byte),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .has_result (has_result),
    .result     (core_result)
  );

  sdr_out_reg u_out_reg (
    .clk         (clk),
    .rst         (rst),
    .load        (advance && has_result),
    .load_result (core_result),
    .busy        (out_busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .held_result (out_result)
  );

  // Drive result fields
  assign write_valid   = out_result.write_valid;
  assign write_address = out_result.write_address;
  assign write_data    = out_result.write_data;
  assign reply_kind    = out_result.reply_kind;
  assign session_done  = out_result.session_done;

endmodule
